// ===== sv/sps_pkg.sv =====
package sps_pkg;

   localparam int MAX_SERIES_LEN = 4096;
   localparam int SAMPLE_W = 16;
   localparam int INDEX_W = 12;
   localparam int COUNT_W = $clog2(MAX_SERIES_LEN + 2);
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SERIES_LEN);
   localparam logic [COUNT_W-1:0] MIN_COUNT = COUNT_W'(3);

   localparam logic [CSR_INDEX_W-1:0] CSR_PROM_FLOOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_SPACING = 1'd1;

   typedef enum logic [1:0] {
      STATUS_FOUND = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic                last;
      logic [SAMPLE_W-1:0] sample;
   } item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] peak_value;
      logic [INDEX_W-1:0]  peak_index;
      status_type          status;
   } result_type;

   typedef struct packed {
      logic step;
      logic last;
   } step_ctrl_type;

endpackage

// ===== sv/sps_in_reg.sv =====
module sps_in_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sps_pkg::REQ_DATA_W-1:0] req_tdata,  // sample
   input  logic                        req_tlast,
   input  logic                        advance,
   output logic                        item_valid,
   output sps_pkg::item_type           item
);

   logic              valid_ff;
   logic              valid_in;
   sps_pkg::item_type item_ff;
   logic              load;

   assign req_tready = !valid_ff || advance;
   assign load = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.sample <= req_tdata[sps_pkg::SAMPLE_W-1:0];
         item_ff.last <= req_tlast;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// ===== sv/sps_core.sv =====
module sps_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [sps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [15:0]                        csr_data,
   input  sps_pkg::step_ctrl_type             ctrl,
   input  logic [sps_pkg::SAMPLE_W-1:0]       sample,
   output logic                               result_valid,
   output sps_pkg::result_type                result
);

   logic [15:0]                  min_prom_ff;
   logic [15:0]                  min_dist_ff;
   logic [sps_pkg::SAMPLE_W-1:0] older_ff;
   logic [sps_pkg::SAMPLE_W-1:0] newer_ff;
   logic [sps_pkg::COUNT_W-1:0]  count_ff;
   logic                         found_ff;
   logic [sps_pkg::INDEX_W-1:0]  best_index_ff;
   logic [sps_pkg::SAMPLE_W-1:0] best_value_ff;
   logic [sps_pkg::SAMPLE_W-1:0] best_prom_ff;
   logic [sps_pkg::INDEX_W-1:0]  last_acc_ff;

   logic [sps_pkg::COUNT_W-1:0]  count_in;
   logic                         found_in;
   logic [sps_pkg::INDEX_W-1:0]  best_index_in;
   logic [sps_pkg::SAMPLE_W-1:0] best_value_in;
   logic [sps_pkg::SAMPLE_W-1:0] best_prom_in;
   logic [sps_pkg::INDEX_W-1:0]  last_acc_in;

   logic                         examine;
   logic [sps_pkg::INDEX_W-1:0]  idx;
   logic [sps_pkg::SAMPLE_W-1:0] shoulder;
   logic [sps_pkg::SAMPLE_W-1:0] prom;
   logic [15:0]                  spacing;
   logic [15:0]                  gap;
   logic                         qualify;
   logic                         far_enough;
   logic                         take;
   logic                         better;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_prom_ff <= '0;
         min_dist_ff <= 16'd1;
      end else if (csr_write) begin
         if (csr_index == sps_pkg::CSR_PROM_FLOOR) begin
            min_prom_ff <= csr_data;
         end else if (csr_index == sps_pkg::CSR_PEAK_SPACING) begin
            min_dist_ff <= csr_data;
         end
      end
   end

   always_comb begin
      examine = (count_ff >= sps_pkg::COUNT_W'(2)) && (count_ff < sps_pkg::MAX_COUNT);
      idx = count_ff[sps_pkg::INDEX_W-1:0] - sps_pkg::INDEX_W'(1);
      shoulder = ($signed(older_ff) > $signed(sample)) ? older_ff : sample;
      prom = newer_ff - shoulder;
      spacing = (min_dist_ff == '0) ? 16'd1 : min_dist_ff;
      gap = 16'(idx) - 16'(last_acc_ff);
      qualify = ($signed(newer_ff) > $signed(older_ff)) &&
                ($signed(newer_ff) >= $signed(sample)) &&
                ($signed(prom) >= $signed(min_prom_ff));
      far_enough = !found_ff || (gap >= spacing);
      take = examine && qualify && far_enough;
      better = !found_ff || ($signed(prom) > $signed(best_prom_ff)) ||
               ($signed(newer_ff) > $signed(best_value_ff));

      count_in = (count_ff <= sps_pkg::MAX_COUNT) ? count_ff + sps_pkg::COUNT_W'(1) : count_ff;
      last_acc_in = take ? idx : last_acc_ff;
      if (take && better) begin
         found_in = 1'b1;
         best_index_in = idx;
         best_value_in = newer_ff;
         best_prom_in = prom;
      end else begin
         found_in = found_ff;
         best_index_in = best_index_ff;
         best_value_in = best_value_ff;
         best_prom_in = best_prom_ff;
      end

      result_valid = ctrl.step && ctrl.last;
      if ((count_in < sps_pkg::MIN_COUNT) || (count_in > sps_pkg::MAX_COUNT)) begin
         result.status = sps_pkg::STATUS_ERROR;
         result.peak_index = '0;
         result.peak_value = '0;
      end else if (!found_in) begin
         result.status = sps_pkg::STATUS_NONE;
         result.peak_index = '0;
         result.peak_value = '0;
      end else begin
         result.status = sps_pkg::STATUS_FOUND;
         result.peak_index = best_index_in;
         result.peak_value = best_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl.step && ctrl.last)) begin
         older_ff <= '0;
         newer_ff <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
         best_index_ff <= '0;
         best_value_ff <= '0;
         best_prom_ff <= '0;
         last_acc_ff <= '0;
      end else if (ctrl.step) begin
         older_ff <= newer_ff;
         newer_ff <= sample;
         count_ff <= count_in;
         found_ff <= found_in;
         best_index_ff <= best_index_in;
         best_value_ff <= best_value_in;
         best_prom_ff <= best_prom_in;
         last_acc_ff <= last_acc_in;
      end
   end

endmodule

// ===== sv/sps_out_reg.sv =====
module sps_out_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  sps_pkg::result_type            result,
   output logic                           slot_free,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sps_pkg::RSP_DATA_W-1:0] rsp_tdata  // status, peak_index, peak_value
);

   logic                valid_ff;
   logic                valid_in;
   sps_pkg::result_type result_ff;

   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = sps_pkg::RSP_DATA_W'(result_ff);

endmodule

// ===== sv/series_peak_selector_top.sv =====
// A final sample word is held in the input register, then its result is loaded into the
// result register and offered from there once that register is free to take it.
// Throughput: one sample word per cycle; a final word waits only while the result
// register holds an untaken word.
// Reset is synchronous and active high: series state clears, the prominence threshold
// returns to 0 and the peak spacing to 1.
module series_peak_selector_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sps_pkg::REQ_DATA_W-1:0]     req_tdata,  // sample
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sps_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // status, peak_index, peak_value
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [15:0]                        csr_data
);

   logic                   item_valid;
   sps_pkg::item_type      item;
   logic                   advance;
   logic                   slot_free;
   sps_pkg::step_ctrl_type ctrl;
   logic                   result_valid;
   sps_pkg::result_type    result;

   assign csr_ready = 1'b1;
   assign advance = item_valid && (!item.last || slot_free);
   assign ctrl = '{step: advance, last: item.last};

   sps_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sps_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .ctrl         (ctrl),
      .sample       (item.sample),
      .result_valid (result_valid),
      .result       (result)
   );

   sps_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (result_valid),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_result_into_free_slot : assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over an untaken result word");

   a_empty_result_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] != sps_pkg::STATUS_FOUND))
         |-> (rsp_tdata[29:2] == '0))
      else $error("peak fields not zero without a peak");

   a_final_word_held : assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.last && !slot_free) |=> (item_valid && $stable(item)))
      else $error("stalled final sample word lost");

endmodule
